@@ sv/md5_stream_hasher_defines.svh @@
// Assertion macros for the MD5 stream hasher.
// Depends on nothing; the asserting modules need clk_i and rst_ni in scope.
`ifndef MD5_STREAM_HASHER_DEFINES_SVH
`define MD5_STREAM_HASHER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MD5_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("md5 assertion failed");
`define MD5_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("md5 forbidden condition");
`else
`define MD5_ASSERT(lbl, prop)
`define MD5_ASSERT_NEVER(lbl, cond)
`endif
`endif

@@ sv/md5sh_pkg.sv @@
// Types, constants and round tables for the MD5 stream hasher.
// No dependencies.
package md5sh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_low;
  } out_t;

  typedef logic [15:0][31:0] blk_words_t;
  typedef logic [63:0][7:0]  blk_bytes_t;

  typedef struct packed {
    blk_words_t words;
    logic       is_final;
  } blk_t;

  typedef enum logic [2:0] {
    FS_BYTE = 3'b001,
    FS_PAD  = 3'b010,
    FS_LEN  = 3'b100
  } front_state_e;

  typedef enum logic [2:0] {
    CS_IDLE = 3'b001,
    CS_RUN  = 3'b010,
    CS_FIN  = 3'b100
  } core_state_e;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

endpackage

@@ sv/md5sh_queue.sv @@
// Two-entry block queue between the packer front end and the round core.
// Depends on md5sh_pkg.
module md5sh_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  md5sh_pkg::blk_t push_data_i,
  output logic            full_o,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output md5sh_pkg::blk_t pop_data_o
);
  import md5sh_pkg::*;

  blk_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o      = (cnt_q == 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/md5sh_front.sv @@
// Byte packer and padding generator: builds 64-byte blocks for the queue.
// Depends on md5sh_pkg.
module md5sh_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  md5sh_pkg::in_t   in_data_i,
  output logic             push_o,
  output md5sh_pkg::blk_t  push_data_o,
  input  logic             full_i
);
  import md5sh_pkg::*;

  front_state_e state_q, state_d;
  blk_bytes_t   buf_q, buf_d;
  logic [60:0]  cnt_q, cnt_d;
  logic [5:0]   pos;
  logic [63:0]  bit_len;
  logic         accept;
  blk_bytes_t   pad_bytes;
  blk_words_t   pad_words, len_words;

  assign pos        = cnt_q[5:0];
  assign bit_len    = {cnt_q, 3'b000};
  assign in_stall_o = !(state_q == FS_BYTE) || full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    pad_bytes = buf_q;
    for (int k = 0; k < 64; k++) begin
      if (6'(k) == pos) begin
        pad_bytes[k] = PAD_BYTE;
      end else if (6'(k) > pos) begin
        pad_bytes[k] = 8'h00;
      end
    end
    pad_words = blk_words_t'(pad_bytes);
    if (pos < 6'd56) begin
      pad_words[14] = bit_len[31:0];
      pad_words[15] = bit_len[63:32];
    end
    len_words     = '0;
    len_words[14] = bit_len[31:0];
    len_words[15] = bit_len[63:32];
  end

  always_comb begin
    state_d     = state_q;
    buf_d       = buf_q;
    cnt_d       = cnt_q;
    push_o      = 1'b0;
    push_data_o = '{words: blk_words_t'(buf_q), is_final: 1'b0};
    unique case (state_q)
      FS_BYTE: begin
        if (accept) begin
          if (in_data_i.byte_valid) begin
            buf_d[pos] = in_data_i.data_byte;
            cnt_d      = cnt_q + 61'd1;
            if (pos == 6'd63) begin
              push_o      = 1'b1;
              push_data_o = '{words: blk_words_t'(buf_d), is_final: 1'b0};
            end
          end
          if (in_data_i.last) begin
            state_d = FS_PAD;
          end
        end
      end
      FS_PAD: begin
        if (!full_i) begin
          push_o = 1'b1;
          if (pos < 6'd56) begin
            push_data_o = '{words: pad_words, is_final: 1'b1};
            cnt_d       = '0;
            state_d     = FS_BYTE;
          end else begin
            push_data_o = '{words: pad_words, is_final: 1'b0};
            state_d     = FS_LEN;
          end
        end
      end
      FS_LEN: begin
        if (!full_i) begin
          push_o      = 1'b1;
          push_data_o = '{words: len_words, is_final: 1'b1};
          cnt_d       = '0;
          state_d     = FS_BYTE;
        end
      end
      default: state_d = FS_BYTE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_BYTE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

@@ sv/md5sh_core.sv @@
// MD5 round engine: one round per cycle, chaining words and digest register.
// Depends on md5sh_pkg and md5_stream_hasher_defines.svh.
`include "md5_stream_hasher_defines.svh"
module md5sh_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            blk_valid_i,
  output logic            blk_pop_o,
  input  md5sh_pkg::blk_t blk_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output md5sh_pkg::out_t out_data_o
);
  import md5sh_pkg::*;

  core_state_e state_q, state_d;
  logic [5:0]  round_q, round_d;
  logic [31:0] a_q, b_q, c_q, d_q, a_d, b_d, c_d, d_d;
  logic [31:0] chain_q [4];
  logic [31:0] chain_d [4];
  blk_words_t  msg_q;
  logic        is_final_q;
  logic        out_valid_q, out_valid_d;
  out_t        out_q, out_d;
  logic [31:0] f, tmp;
  logic [3:0]  g;
  logic [63:0] rot;
  logic        out_free;

  function automatic logic [31:0] bswap(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  assign out_free    = !out_valid_q || !out_stall_i;
  assign blk_pop_o   = (state_q == CS_IDLE) && blk_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    unique case (round_q[5:4])
      2'd0: begin
        f = (b_q & c_q) | (~b_q & d_q);
        g = round_q[3:0];
      end
      2'd1: begin
        f = (b_q & d_q) | (c_q & ~d_q);
        g = 4'(round_q[3:0] * 4'd5 + 4'd1);
      end
      2'd2: begin
        f = b_q ^ c_q ^ d_q;
        g = 4'(round_q[3:0] * 4'd3 + 4'd5);
      end
      default: begin
        f = c_q ^ (b_q | ~d_q);
        g = 4'(round_q[3:0] * 4'd7);
      end
    endcase
    tmp = a_q + f + ROUND_K[round_q] + msg_q[g];
    rot = {tmp, tmp} << ROT_AMT[{round_q[5:4], round_q[1:0]}];
  end

  always_comb begin
    state_d     = state_q;
    round_d     = round_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    d_d         = d_q;
    chain_d     = chain_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      CS_IDLE: begin
        if (blk_valid_i) begin
          a_d     = chain_q[0];
          b_d     = chain_q[1];
          c_d     = chain_q[2];
          d_d     = chain_q[3];
          round_d = '0;
          state_d = CS_RUN;
        end
      end
      CS_RUN: begin
        a_d     = d_q;
        d_d     = c_q;
        c_d     = b_q;
        b_d     = b_q + rot[63:32];
        round_d = round_q + 6'd1;
        if (round_q == 6'd63) begin
          state_d = CS_FIN;
        end
      end
      CS_FIN: begin
        if (!is_final_q) begin
          chain_d[0] = chain_q[0] + a_q;
          chain_d[1] = chain_q[1] + b_q;
          chain_d[2] = chain_q[2] + c_q;
          chain_d[3] = chain_q[3] + d_q;
          state_d    = CS_IDLE;
        end else if (out_free) begin
          out_d.digest_high = {bswap(chain_q[0] + a_q), bswap(chain_q[1] + b_q)};
          out_d.digest_low  = {bswap(chain_q[2] + c_q), bswap(chain_q[3] + d_q)};
          out_valid_d       = 1'b1;
          chain_d           = '{INIT_A, INIT_B, INIT_C, INIT_D};
          state_d           = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      round_q     <= '0;
      chain_q     <= '{INIT_A, INIT_B, INIT_C, INIT_D};
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      chain_q     <= chain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    out_q <= out_d;
    if (blk_pop_o) begin
      msg_q      <= blk_data_i.words;
      is_final_q <= blk_data_i.is_final;
    end
  end

  `MD5_ASSERT(a_round_start, blk_pop_o |=> (round_q == 6'd0) && (state_q == CS_RUN))
  `MD5_ASSERT(a_out_from_fin, $rose(out_valid_q) |-> $past(state_q == CS_FIN))
  `MD5_ASSERT(a_chain_reinit, (state_q == CS_FIN && is_final_q && out_free) |=> (chain_q[0] == INIT_A) && (chain_q[3] == INIT_D))
  `MD5_ASSERT_NEVER(a_no_pop_busy, blk_pop_o && (state_q != CS_IDLE))

endmodule

@@ sv/md5_stream_hasher.sv @@
// Top level of the MD5 stream hasher: front end, block queue, round core.
// Depends on md5sh_pkg, md5sh_front, md5sh_queue, md5sh_core.
//
//   channel | direction | handshake              | payload
//   in      | to block  | in_valid_i / in_stall_o | in_data_i  (md5sh_pkg::in_t)
//   out     | from block| out_valid_o / out_stall_i| out_data_o (md5sh_pkg::out_t)
//
// Bytes are taken one per cycle while the front is not emitting padding blocks and the queue has room.
// Each 64-byte block passes through the round core in order: load, 64 rounds, add.
// An item marked last makes the front emit one or two padding blocks.
// Reset is asynchronous and needs no clearing pass; the block is ready at once.
// A stalled digest holds the core after its final block; the front keeps filling until the queue is full.
module md5_stream_hasher (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  md5sh_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output md5sh_pkg::out_t out_data_o
);
  import md5sh_pkg::*;

  logic push, full, pop_valid, pop;
  blk_t push_data, pop_data;

  md5sh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  md5sh_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_data)
  );

  md5sh_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_valid_i (pop_valid),
    .blk_pop_o   (pop),
    .blk_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ tb/tb_md5_stream_hasher.sv @@
// Self-checking testbench for md5_stream_hasher: byte-stream MD5 digests.
// Depends on md5sh_pkg and the md5_stream_hasher RTL; predicts digests in SV.
`timescale 1ns / 100ps
module tb_md5_stream_hasher;
  import md5sh_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  md5_stream_hasher u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // predictor state
  logic [31:0] chain [4];
  logic [31:0] blk [16];
  logic [60:0] byte_cnt;

  in_t  pending_items [$];
  out_t digest_q [$];
  int   n_err = 0;
  int   idle_cycles = 0;

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] bswap(logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  task automatic add_item(in_t it);
    pending_items = {pending_items, it};
  endtask

  task automatic md5_compress();
    logic [31:0] a, b, c, d, f, t;
    int g;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        f = (b & c) | (~b & d); g = r;
      end else if (r < 32) begin
        f = (b & d) | (c & ~d); g = (5 * r + 1) % 16;
      end else if (r < 48) begin
        f = b ^ c ^ d; g = (3 * r + 5) % 16;
      end else begin
        f = c ^ (b | ~d); g = (7 * r) % 16;
      end
      t = d; d = c; c = b;
      b = b + rol(a + f + ROUND_K[r] + blk[g],
                  int'(ROT_AMT[((r / 16) * 4) + (r % 4)]));
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic set_byte(int pos, logic [7:0] v);
    blk[pos / 4][(pos % 4) * 8 +: 8] = v;
  endtask

  task automatic chain_reset();
    chain[0] = INIT_A; chain[1] = INIT_B; chain[2] = INIT_C; chain[3] = INIT_D;
    byte_cnt = '0;
  endtask

  task automatic predict_digest(in_t it);
    int pos;
    logic [63:0] bits;
    out_t res;
    if (it.byte_valid) begin
      pos = int'(byte_cnt[5:0]);
      set_byte(pos, it.data_byte);
      byte_cnt++;
      if (pos == 63) md5_compress();
    end
    if (!it.last) return;
    bits = {byte_cnt, 3'b000};
    pos = int'(byte_cnt[5:0]);
    set_byte(pos, PAD_BYTE);
    for (int i = pos + 1; i < 64; i++) set_byte(i, 8'h00);
    if (pos >= 56) begin
      md5_compress();
      for (int i = 0; i < 56; i++) set_byte(i, 8'h00);
    end
    blk[14] = bits[31:0];
    blk[15] = bits[63:32];
    md5_compress();
    res.digest_high = {bswap(chain[0]), bswap(chain[1])};
    res.digest_low = {bswap(chain[2]), bswap(chain[3])};
    digest_q = {digest_q, res};
    chain_reset();
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 80);
  endfunction

  function automatic in_t mk_item(logic [7:0] d, logic v, logic l);
    in_t it;
    it.data_byte = d; it.byte_valid = v; it.last = l;
    return it;
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_digest(in_data_i);
        void'(pending_items.pop_front());
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled transaction
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_items[0];
        in_gap <= (pending_items.size() > 1) ? gap_len() : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        idle_cycles <= 0;
        if (digest_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected digest %h", out_data_o);
        end else begin
          if (out_data_o.digest_high !== digest_q[0].digest_high ||
              out_data_o.digest_low !== digest_q[0].digest_low) begin
            n_err++;
            if (n_err <= 10)
              $display("digest exp %h %h got %h %h", digest_q[0].digest_high,
                       digest_q[0].digest_low, out_data_o.digest_high,
                       out_data_o.digest_low);
          end
          void'(digest_q.pop_front());
        end
      end else if (in_valid_i && !in_stall_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        out_gap <= gap_len();
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("md5_stream_hasher: mismatch");
      $finish;
    end
  end

  task automatic add_message(int len, bit empty_end);
    for (int i = 0; i < len; i++)
      add_item(mk_item(8'($urandom), 1'b1, (i == len - 1) && !empty_end));
    if (empty_end || len == 0)
      add_item(mk_item(8'($urandom), 1'b0, 1'b1));
  endtask

  initial begin
    int total;
    int len;
    for (int i = 0; i < 16; i++) blk[i] = '0;
    chain_reset();
    // directed: empty, extremes, idle noise, valid+last, byte-less end
    add_item(mk_item(8'h00, 1'b0, 1'b1));
    add_item(mk_item(8'hff, 1'b0, 1'b0));
    add_item(mk_item(8'hff, 1'b1, 1'b1));
    add_item(mk_item(8'h00, 1'b1, 1'b0));
    add_item(mk_item(8'h55, 1'b0, 1'b0));
    add_item(mk_item(8'haa, 1'b1, 1'b1));
    add_item(mk_item(8'h00, 1'b1, 1'b0));
    add_item(mk_item(8'h80, 1'b0, 1'b1));
    add_item(mk_item(8'h00, 1'b0, 1'b1));
    total = 9;
    // random: boundary lengths around 55/56/63/64 weighted
    while (total < 1550) begin
      case ($urandom_range(0, 5))
        0: len = $urandom_range(54, 57);
        1: len = $urandom_range(62, 65);
        2: len = $urandom_range(119, 129);
        3: len = $urandom_range(0, 8);
        default: len = $urandom_range(0, 70);
      endcase
      add_message(len, $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0)
        add_item(mk_item(8'($urandom), 1'b0, 1'b0));
      total += len + 1;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_items.size() == 0 && digest_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (n_err == 0) begin
      $display("md5_stream_hasher: match");
    end else begin
      $display("md5_stream_hasher: mismatch");
    end
    $finish;
  end

endmodule
